### design/scpa_pkg.sv
// shared types, constants and class lookup for the size class pool allocator
package scpa_pkg;

  localparam int NUM_CLASSES     = 28;
  localparam int SLOTS_PER_CLASS = 256;
  localparam int TABLE_CLASSES   = 28;
  localparam int USED_CLASSES    = (NUM_CLASSES < TABLE_CLASSES) ? NUM_CLASSES : TABLE_CLASSES;
  localparam int CLS_W   = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int SLOT_W  = (SLOTS_PER_CLASS > 1) ? $clog2(SLOTS_PER_CLASS) : 1;
  localparam int LINK_W  = SLOT_W + 1;
  localparam int LINK_DEPTH = NUM_CLASSES * SLOTS_PER_CLASS;
  localparam int LINK_AW = $clog2(LINK_DEPTH);
  localparam int QUEUE_DEPTH = 2;
  localparam int IN_W  = 80;
  localparam int OUT_W = 24;

  typedef enum logic [1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_FREE    = 2'd1,
    CMD_REALLOC = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_POOL      = 3'd0,
    ST_SYSTEM    = 3'd1,
    ST_EXHAUSTED = 3'd2,
    ST_KEPT      = 3'd3,
    ST_IGNORED   = 3'd4
  } status_e;

  typedef struct packed {
    status_e    status;
    logic [4:0] size_class;
    logic [7:0] slot_out;
    logic       old_released;
    logic       old_to_system;
  } res_t;

  // one decoded command as handed from front to back
  typedef struct packed {
    logic              take;
    logic [CLS_W-1:0]  take_cls;
    logic              give;
    logic [CLS_W-1:0]  give_cls;
    logic [SLOT_W-1:0] give_slot;
    logic              sys_if_ok;
    res_t              res;
  } op_t;

  typedef struct packed {
    logic             oversize;
    logic [CLS_W-1:0] idx;
  } cls_t;

  function automatic logic [31:0] class_bytes(input int i);
    logic [31:0] b;
    case (i)
      0:  b = 32'd8;
      1:  b = 32'd16;
      2:  b = 32'd24;
      3:  b = 32'd32;
      4:  b = 32'd48;
      5:  b = 32'd64;
      6:  b = 32'd96;
      7:  b = 32'd128;
      8:  b = 32'd192;
      9:  b = 32'd256;
      10: b = 32'd384;
      11: b = 32'd512;
      12: b = 32'd768;
      13: b = 32'd1024;
      14: b = 32'd2048;
      15: b = 32'd4096;
      16: b = 32'd8192;
      17: b = 32'd16384;
      18: b = 32'd32768;
      19: b = 32'd65536;
      20: b = 32'd131072;
      21: b = 32'd196608;
      22: b = 32'd262144;
      23: b = 32'd393216;
      24: b = 32'd524288;
      25: b = 32'd786432;
      26: b = 32'd1048576;
      default: b = 32'd2097152;
    endcase
    return b;
  endfunction

  // first class at least as large as the request, else oversize
  function automatic cls_t class_of(input logic [31:0] bytes);
    cls_t r;
    r.oversize = 1'b1;
    r.idx      = '0;
    for (int c = USED_CLASSES - 1; c >= 0; c--) begin
      if (class_bytes(c) >= bytes) begin
        r.oversize = 1'b0;
        r.idx      = CLS_W'(c);
      end
    end
    return r;
  endfunction

endpackage

### design/scpa_front.sv
// front end: decodes and classifies one command per beat
module scpa_front (
  input  logic [scpa_pkg::IN_W-1:0] in_data_i,
  output scpa_pkg::op_t             op_o
);
  import scpa_pkg::*;

  logic [1:0]  cmd;
  logic [31:0] size;
  logic [31:0] old_size;
  logic [7:0]  slot;
  logic        is_null;
  logic        slot_ok;
  cls_t        nc;
  cls_t        oc;

  assign cmd      = in_data_i[1:0];
  assign size     = in_data_i[33:2];
  assign old_size = in_data_i[65:34];
  assign slot     = in_data_i[73:66];
  assign is_null  = in_data_i[74];
  assign slot_ok  = 32'(slot) < 32'(SLOTS_PER_CLASS);
  assign nc       = class_of(size);
  assign oc       = class_of(old_size);

  always_comb begin
    op_o           = '0;
    op_o.res.status = ST_IGNORED;
    op_o.give_slot = SLOT_W'(slot);
    case (cmd)
      CMD_ALLOC, CMD_REALLOC: begin
        if (cmd == CMD_ALLOC || is_null) begin
          if (nc.oversize) begin
            op_o.res.status = ST_SYSTEM;
          end else begin
            op_o.take = 1'b1;
            op_o.take_cls = nc.idx;
            op_o.res.status = ST_EXHAUSTED;
            op_o.res.size_class = 5'(nc.idx);
          end
        end else if (oc.oversize && nc.oversize) begin
          op_o.res.status = ST_SYSTEM;
        end else if (oc == nc) begin
          op_o.res.status = ST_KEPT;
          op_o.res.size_class = 5'(oc.idx);
          op_o.res.slot_out = slot;
        end else begin
          if (nc.oversize) begin
            op_o.res.status = ST_SYSTEM;
          end else begin
            op_o.take = 1'b1;
            op_o.take_cls = nc.idx;
            op_o.res.status = ST_EXHAUSTED;
            op_o.res.size_class = 5'(nc.idx);
          end
          if (oc.oversize) begin
            op_o.sys_if_ok = 1'b1;
          end else if (slot_ok) begin
            op_o.give = 1'b1;
            op_o.give_cls = oc.idx;
          end
        end
      end
      CMD_FREE: begin
        if (!is_null) begin
          if (nc.oversize) begin
            op_o.res.status = ST_SYSTEM;
            op_o.res.old_to_system = 1'b1;
          end else if (slot_ok) begin
            op_o.give = 1'b1;
            op_o.give_cls = nc.idx;
            op_o.res.status = ST_POOL;
            op_o.res.size_class = 5'(nc.idx);
          end
        end
      end
      default: ;
    endcase
  end

endmodule

### design/scpa_queue.sv
// short fifo of decoded commands between front and back
module scpa_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  scpa_pkg::op_t push_data_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output scpa_pkg::op_t pop_data_o
);
  import scpa_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  op_t              mem_q [QUEUE_DEPTH];
  logic [PW-1:0]    wr_q, rd_q;
  logic [PW:0]      cnt_q;
  logic             push, pop;

  assign push_ready_o = cnt_q < (PW+1)'(QUEUE_DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_data_o   = mem_q[rd_q];
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= (wr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      if (pop) rd_q <= (rd_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

endmodule

### design/scpa_back.sv
// back end: free list heads, fresh counters and link memory
module scpa_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          op_valid_i,
  output logic          op_ready_o,
  input  scpa_pkg::op_t op_i,
  output logic          res_valid_o,
  input  logic          res_ready_i,
  output scpa_pkg::res_t res_o
);
  import scpa_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_TAKE = 5'b00010,
    S_LINK = 5'b00100,
    S_GIVE = 5'b01000,
    S_DONE = 5'b10000
  } state_e;

  state_e             state_q;
  op_t                op_q;
  logic [SLOT_W-1:0]  free_head_q [NUM_CLASSES];
  logic               head_valid_q [NUM_CLASSES];
  logic [SLOT_W:0]    fresh_q [NUM_CLASSES];
  logic [LINK_W-1:0]  link_mem [LINK_DEPTH];
  logic [LINK_W-1:0]  link_rd_q;
  logic               rd_en, wr_en;
  logic [LINK_AW-1:0] rd_addr, wr_addr;
  logic [LINK_W-1:0]  wr_data;
  logic [CLS_W-1:0]   tc, gc;

  function automatic logic [LINK_AW-1:0] addr_of(input logic [CLS_W-1:0] c,
                                                 input logic [SLOT_W-1:0] s);
    return LINK_AW'(LINK_AW'(c) * LINK_AW'(SLOTS_PER_CLASS)) + LINK_AW'(s);
  endfunction

  assign tc = op_q.take_cls;
  assign gc = op_q.give_cls;
  assign op_ready_o  = state_q == S_IDLE;
  assign res_valid_o = state_q == S_DONE;
  assign res_o       = op_q.res;
  assign rd_en   = (state_q == S_TAKE) && head_valid_q[tc];
  assign rd_addr = addr_of(tc, free_head_q[tc]);
  assign wr_en   = state_q == S_GIVE;
  assign wr_addr = addr_of(gc, op_q.give_slot);
  assign wr_data = head_valid_q[gc] ? LINK_W'(free_head_q[gc]) : LINK_W'(SLOTS_PER_CLASS);

  always_ff @(posedge clk_i) begin
    if (wr_en) link_mem[wr_addr] <= wr_data;
    if (rd_en) link_rd_q <= link_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q <= '0;
      for (int c = 0; c < NUM_CLASSES; c++) begin
        free_head_q[c] <= '0;
        head_valid_q[c] <= 1'b0;
        fresh_q[c] <= '0;
      end
    end else begin
      case (state_q)
        S_IDLE: begin
          if (op_valid_i) begin
            op_q <= op_i;
            state_q <= op_i.take ? S_TAKE : (op_i.give ? S_GIVE : S_DONE);
          end
        end
        S_TAKE: begin
          if (head_valid_q[tc]) begin
            op_q.res.slot_out <= 8'(free_head_q[tc]);
            state_q <= S_LINK;
          end else if (fresh_q[tc] < (SLOT_W+1)'(SLOTS_PER_CLASS)) begin
            op_q.res.slot_out <= 8'(fresh_q[tc]);
            op_q.res.status <= ST_POOL;
            op_q.res.old_to_system <= op_q.sys_if_ok;
            fresh_q[tc] <= fresh_q[tc] + 1'b1;
            state_q <= op_q.give ? S_GIVE : S_DONE;
          end else begin
            // class is exhausted: old block stays untouched
            op_q.give <= 1'b0;
            state_q <= S_DONE;
          end
        end
        S_LINK: begin
          if (link_rd_q < LINK_W'(SLOTS_PER_CLASS)) begin
            free_head_q[tc] <= link_rd_q[SLOT_W-1:0];
          end else begin
            free_head_q[tc] <= '0;
            head_valid_q[tc] <= 1'b0;
          end
          op_q.res.status <= ST_POOL;
          op_q.res.old_to_system <= op_q.sys_if_ok;
          state_q <= op_q.give ? S_GIVE : S_DONE;
        end
        S_GIVE: begin
          free_head_q[gc] <= op_q.give_slot;
          head_valid_q[gc] <= 1'b1;
          op_q.res.old_released <= 1'b1;
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (res_ready_i) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

### design/size_class_pool_allocator_top.sv
// top level of the size class pool allocator
//
// channel   | dir | beat contents (low bit first)
// s_axis    | in  | command[1:0] size[33:2] old_size[65:34] slot[73:66] handle_null[74]
// m_axis    | out | status[2:0] size_class[7:3] slot_out[15:8] old_released[16]
//           |     | old_to_system[17]
//
// a command passes through the back end states in order: a pop, a head lookup, a link
// memory read when the freed list is used, a link write on release, a result held until taken
// the registered read of the link memory adds the link state on a list pop
// a two deep queue lets the front accept while the back works or the result stalls
// reset clears heads, valid flags and fresh counters; link memory is not cleared
module size_class_pool_allocator_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,  // command, size, old_size, slot, handle_null, zero pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata   // status, size_class, slot_out, old_released,
                                     // old_to_system, zero pad
);
  import scpa_pkg::*;

  op_t  front_op;
  op_t  q_op;
  logic q_valid, q_ready;
  res_t res;

  // classify in front of the queue
  scpa_front u_front (
    .in_data_i (s_axis_tdata),
    .op_o      (front_op)
  );

  scpa_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (s_axis_tvalid),
    .push_ready_o (s_axis_tready),
    .push_data_i  (front_op),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (q_op)
  );

  // list work and result hold
  scpa_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_valid_i  (q_valid),
    .op_ready_o  (q_ready),
    .op_i        (q_op),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tdata = {6'd0, res.old_to_system, res.old_released, res.slot_out,
                         res.size_class, res.status};

endmodule

### design/scpa_checker.sv
// port level checks for the size class pool allocator
module scpa_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);
  import scpa_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[2:0] <= 3'(ST_IGNORED))
    else $error("bad status code");

  a_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[16] |-> m_axis_tdata[2:0] == 3'(ST_POOL)
    || m_axis_tdata[2:0] == 3'(ST_SYSTEM))
    else $error("release with wrong status");

  a_system: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[17] |-> !m_axis_tdata[16] &&
    (m_axis_tdata[2:0] == 3'(ST_POOL) || m_axis_tdata[2:0] == 3'(ST_SYSTEM)))
    else $error("system free with wrong flags");

endmodule

bind size_class_pool_allocator_top scpa_checker u_scpa_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
